[hdl/pas_pkg.sv]
// pas_pkg: shared types and constants for the pid_antiwindup_separation block
// config register set, register index codes and the integrator stage word
// no dependencies
`timescale 1ns / 1ps

package pas_pkg;

  localparam int DATA_W   = 16;   // setpoint, gains, limits, measurement, drive
  localparam int THR_W    = 17;   // separation threshold
  localparam int ILIM_W   = 23;   // integral clamp magnitude
  localparam int ERR_W    = 18;   // setpoint - measurement
  localparam int DIFF_W   = 19;   // error - previous error
  localparam int ACC_W    = 24;   // accumulated error
  localparam int ASUM_W   = ACC_W + 1;   // integral before the clamp
  localparam int IDX_W    = 3;
  localparam int CDATA_W  = 23;   // widest register
  localparam int FRAC_W   = 8;    // Q8.8 gains
  localparam int PP_W     = DATA_W + ERR_W;
  localparam int PD_W     = DATA_W + DIFF_W;
  localparam int PI_W     = DATA_W + ACC_W;
  localparam int SUM_W    = PI_W + 1;
  localparam int SH_W     = SUM_W - FRAC_W;

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_UPPER_LIM  = 3'd4,
    REG_LOWER_LIM  = 3'd5,
    REG_SEP_THR    = 3'd6,
    REG_INTEG_LIM  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] upper_limit;
    logic signed [DATA_W-1:0] lower_limit;
    logic [THR_W-1:0]         sep_thr;
    logic [ILIM_W-1:0]        integ_lim;
  } cfg_t;

  // word handed from the integrator stage to the multiply stage
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  acc;
    logic                     active;
  } integ_t;

endpackage

[hdl/pas_regs.sv]
// pas_regs: configuration register file for the pid block
// decodes the index on the write channel; depends on pas_pkg
`timescale 1ns / 1ps

module pas_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [pas_pkg::IDX_W-1:0]   wr_index,
  input  logic [pas_pkg::CDATA_W-1:0] wr_data,
  output pas_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (pas_pkg::reg_idx_t'(wr_index))
        pas_pkg::REG_SETPOINT:  cfg.setpoint    <= wr_data[pas_pkg::DATA_W-1:0];
        pas_pkg::REG_GAIN_P:    cfg.gain_p      <= wr_data[pas_pkg::DATA_W-1:0];
        pas_pkg::REG_GAIN_I:    cfg.gain_i      <= wr_data[pas_pkg::DATA_W-1:0];
        pas_pkg::REG_GAIN_D:    cfg.gain_d      <= wr_data[pas_pkg::DATA_W-1:0];
        pas_pkg::REG_UPPER_LIM: cfg.upper_limit <= wr_data[pas_pkg::DATA_W-1:0];
        pas_pkg::REG_LOWER_LIM: cfg.lower_limit <= wr_data[pas_pkg::DATA_W-1:0];
        pas_pkg::REG_SEP_THR:   cfg.sep_thr     <= wr_data[pas_pkg::THR_W-1:0];
        pas_pkg::REG_INTEG_LIM: cfg.integ_lim   <= wr_data[pas_pkg::ILIM_W-1:0];
      endcase
    end
  end

endmodule

[hdl/pas_integ.sv]
// pas_integ: error, separation test, conditional accumulate and clamp
// holds the controller state (integral and previous error); depends on pas_pkg
`timescale 1ns / 1ps

module pas_integ (
  input  logic                              clk,
  input  logic                              rst,
  input  pas_pkg::cfg_t                     cfg,
  input  logic signed [pas_pkg::DATA_W-1:0] meas,
  input  logic                              load,
  output pas_pkg::integ_t                   st
);

  logic signed [pas_pkg::ERR_W-1:0]  err;
  logic signed [pas_pkg::ERR_W-1:0]  err_neg;
  logic signed [pas_pkg::DIFF_W-1:0] diff;
  logic [pas_pkg::ERR_W-2:0]         mag;
  logic                              active;
  logic                              add_en;
  logic signed [pas_pkg::ASUM_W-1:0] acc_sum;
  logic signed [pas_pkg::ASUM_W-1:0] acc_pre;
  logic signed [pas_pkg::ASUM_W-1:0] lim_pos;
  logic signed [pas_pkg::ASUM_W-1:0] lim_neg;
  logic signed [pas_pkg::ACC_W-1:0]  acc_next;

  always_comb begin
    err  = pas_pkg::ERR_W'(cfg.setpoint) - pas_pkg::ERR_W'(meas);
    diff = pas_pkg::DIFF_W'(err) - pas_pkg::DIFF_W'(st.err);
    err_neg = -err;
    mag  = err[pas_pkg::ERR_W-1] ? err_neg[pas_pkg::ERR_W-2:0] : err[pas_pkg::ERR_W-2:0];
    active = (mag < cfg.sep_thr);

    // anti-windup: upper test wins when the limits cross
    priority if (meas > cfg.upper_limit) begin
      add_en = err[pas_pkg::ERR_W-1];
    end else if (meas < cfg.lower_limit) begin
      add_en = (err > 0);
    end else begin
      add_en = 1'b1;
    end

    acc_sum = pas_pkg::ASUM_W'(st.acc) + pas_pkg::ASUM_W'(err);
    if (!active) begin
      acc_pre = '0;
    end else if (add_en) begin
      acc_pre = acc_sum;
    end else begin
      acc_pre = pas_pkg::ASUM_W'(st.acc);
    end

    lim_pos = $signed(pas_pkg::ASUM_W'(cfg.integ_lim));
    lim_neg = -lim_pos;
    priority if (acc_pre > lim_pos) begin
      acc_next = lim_pos[pas_pkg::ACC_W-1:0];
    end else if (acc_pre < lim_neg) begin
      acc_next = lim_neg[pas_pkg::ACC_W-1:0];
    end else begin
      acc_next = acc_pre[pas_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.err <= '0;
      st.acc <= '0;
    end else if (load) begin
      st.err    <= err;
      st.acc    <= acc_next;
      st.diff   <= diff;
      st.active <= active;
    end
  end

endmodule

[hdl/pas_mac.sv]
// pas_mac: three gain products, then sum, shift and saturate to the drive value
// two register stages; depends on pas_pkg
`timescale 1ns / 1ps

module pas_mac (
  input  logic                              clk,
  input  pas_pkg::cfg_t                     cfg,
  input  pas_pkg::integ_t                   st,
  input  logic                              load_mul,
  input  logic                              load_out,
  output logic signed [pas_pkg::DATA_W-1:0] drive,
  output logic                              integral_active
);

  logic signed [pas_pkg::PP_W-1:0]  prod_p;
  logic signed [pas_pkg::PD_W-1:0]  prod_d;
  logic signed [pas_pkg::PI_W-1:0]  prod_i;
  logic                             act_m;
  logic signed [pas_pkg::SUM_W-1:0] sum;
  logic signed [pas_pkg::SH_W-1:0]  shifted;
  logic signed [pas_pkg::DATA_W-1:0] sat;
  logic signed [pas_pkg::SH_W-1:0]  max_v;
  logic signed [pas_pkg::SH_W-1:0]  min_v;

  // integral is already zero when separated, so its product drops out too
  always_ff @(posedge clk) begin
    if (load_mul) begin
      prod_p <= pas_pkg::PP_W'(cfg.gain_p) * pas_pkg::PP_W'(st.err);
      prod_d <= pas_pkg::PD_W'(cfg.gain_d) * pas_pkg::PD_W'(st.diff);
      prod_i <= pas_pkg::PI_W'(cfg.gain_i) * pas_pkg::PI_W'(st.acc);
      act_m  <= st.active;
    end
  end

  always_comb begin
    sum = pas_pkg::SUM_W'(prod_p) + pas_pkg::SUM_W'(prod_d) + pas_pkg::SUM_W'(prod_i);
    shifted = sum[pas_pkg::SUM_W-1:pas_pkg::FRAC_W];   // floor divide by 256
    max_v = pas_pkg::SH_W'({1'b0, {(pas_pkg::DATA_W-1){1'b1}}});
    min_v = -max_v - pas_pkg::SH_W'(1);
    priority if (shifted > max_v) begin
      sat = max_v[pas_pkg::DATA_W-1:0];
    end else if (shifted < min_v) begin
      sat = min_v[pas_pkg::DATA_W-1:0];
    end else begin
      sat = shifted[pas_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive           <= sat;
      integral_active <= act_m;
    end
  end

endmodule

[hdl/pid_antiwindup_separation.sv]
// pid_antiwindup_separation: positional PID with integral separation and anti-windup
// top level with pipeline control; depends on pas_pkg, pas_regs, pas_integ, pas_mac
//
// Usage:
//   Configuration words arrive on cfg_valid/cfg_ready with cfg_index (register
//   number 0..7) and cfg_data; cfg_ready is always high. Write only while idle.
//   Measurement words arrive on in_valid/in_ready; each gives one word on
//   out_valid/out_ready carrying drive and integral_active.
//   Pipeline: input register, integrator stage (error, separation, clamp,
//   state update), multiply stage, sum/saturate output register.
//   Throughput: one word per cycle while the receiver keeps up; the
//   integrator state closes its loop in a single stage, so consecutive
//   words follow without gaps.
//   When the receiver stalls, the stages fill up one by one (bubbles
//   collapse); in_ready drops only when all four stages hold a word.
//   Reset clears the configuration registers to zero, the integral and previous error to
//   zero, and empties the pipeline.
`timescale 1ns / 1ps

module pid_antiwindup_separation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pas_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pas_pkg::CDATA_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pas_pkg::DATA_W-1:0] measurement,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pas_pkg::DATA_W-1:0] drive,
  output logic                              integral_active
);

  pas_pkg::cfg_t                     cfg;
  pas_pkg::integ_t                   st;
  logic signed [pas_pkg::DATA_W-1:0] meas;
  logic                              v1;
  logic                              v2;
  logic                              v3;
  logic                              v1_next;
  logic                              v2_next;
  logic                              v3_next;
  logic                              out_valid_next;
  logic                              accept;
  logic                              load2;
  logic                              load3;
  logic                              load4;

  assign cfg_ready = 1'b1;

  pas_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // each stage moves when the one after it is empty or moving
  always_comb begin
    load4    = v3 && (!out_valid || out_ready);
    load3    = v2 && (!v3 || load4);
    load2    = v1 && (!v2 || load3);
    in_ready = !v1 || load2;
    accept   = in_valid && in_ready;

    v1_next        = accept ? 1'b1 : (load2 ? 1'b0 : v1);
    v2_next        = load2  ? 1'b1 : (load3 ? 1'b0 : v2);
    v3_next        = load3  ? 1'b1 : (load4 ? 1'b0 : v3);
    out_valid_next = load4  ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= v1_next;
      v2        <= v2_next;
      v3        <= v3_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meas <= measurement;
    end
  end

  pas_integ u_integ (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .meas (meas),
    .load (load2),
    .st   (st)
  );

  pas_mac u_mac (
    .clk             (clk),
    .cfg             (cfg),
    .st              (st),
    .load_mul        (load3),
    .load_out        (load4),
    .drive           (drive),
    .integral_active (integral_active)
  );

  // stored integral never leaves the clamp window
  a_acc_clamped: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (st.acc <= $signed({1'b0, cfg.integ_lim}) &&
            st.acc >= -$signed({1'b0, cfg.integ_lim})))
    else $error("integral outside clamp window");

  // separation clears the integral
  a_sep_clears: assert property (@(posedge clk) disable iff (rst)
    (v2 && !st.active) |-> (st.acc == '0))
    else $error("integral not cleared on separation");

  // input stalls only with a full pipeline
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && out_valid))
    else $error("input stalled with a bubble in the pipeline");

endmodule

[bench/tb.sv]
// tb: self-checking bench for pid_antiwindup_separation, directed then random control steps
// predicts drive and integral_active per measurement word; depends on pas_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import pas_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     active;
  } ctl_word_t;

  // tracks controller state and the drive words still owed by the block
  class pid_scoreboard;
    logic signed [DATA_W-1:0] setpoint, kp, ki, kd, hi_lim, lo_lim;
    logic [THR_W-1:0]         sep_thr;
    logic [ILIM_W-1:0]        integ_lim;
    logic signed [ACC_W-1:0]  integ;
    logic signed [ERR_W-1:0]  prev_err;
    ctl_word_t                owed_q[$];
    int                       errors;

    function new();
      setpoint = '0; kp = '0; ki = '0; kd = '0; hi_lim = '0; lo_lim = '0;
      sep_thr = '0; integ_lim = '0; integ = '0; prev_err = '0; errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CDATA_W-1:0] d);
      case (idx)
        REG_SETPOINT:  setpoint  = d[DATA_W-1:0];
        REG_GAIN_P:    kp        = d[DATA_W-1:0];
        REG_GAIN_I:    ki        = d[DATA_W-1:0];
        REG_GAIN_D:    kd        = d[DATA_W-1:0];
        REG_UPPER_LIM: hi_lim    = d[DATA_W-1:0];
        REG_LOWER_LIM: lo_lim    = d[DATA_W-1:0];
        REG_SEP_THR:   sep_thr   = d[THR_W-1:0];
        REG_INTEG_LIM: integ_lim = d[ILIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_measurement(logic signed [DATA_W-1:0] m);
      longint    meas, e, mag, acc, lim, sum, q;
      bit        act;
      ctl_word_t w;
      meas = longint'(m);
      e    = longint'(setpoint) - meas;
      mag  = (e < 0) ? -e : e;
      acc  = longint'(integ);
      lim  = longint'(integ_lim);
      if (mag >= longint'(sep_thr)) begin
        act = 1'b0;
        acc = 0;
      end else begin
        act = 1'b1;
        // anti-windup: outside the band only errors pulling back are summed
        if (meas > longint'(hi_lim)) begin
          if (e < 0) acc += e;
        end else if (meas < longint'(lo_lim)) begin
          if (e > 0) acc += e;
        end else begin
          acc += e;
        end
      end
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      sum = longint'(kp) * e + longint'(kd) * (e - longint'(prev_err));
      if (act) sum += longint'(ki) * acc;
      integ    = acc[ACC_W-1:0];
      prev_err = e[ERR_W-1:0];
      q = sum >>> FRAC_W;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      w.drive  = q[DATA_W-1:0];
      w.active = act;
      owed_q.push_back(w);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] drv, logic act);
      ctl_word_t w;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, drive %0d integral_active %0b", $time, drv, act);
        return;
      end
      w = owed_q.pop_front();
      if (drv !== w.drive) begin
        errors++;
        $display("%0t: drive expected %0d, got %0d", $time, w.drive, drv);
      end
      if (act !== w.active) begin
        errors++;
        $display("%0t: integral_active expected %0b, got %0b", $time, w.active, act);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  reg_idx_t                 cfg_index = REG_SETPOINT;
  logic [CDATA_W-1:0]       cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] measurement = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] drive;
  logic                     integral_active;

  pid_scoreboard sb = new();
  int  idle_pct  = 0;
  int  stall_pct = 0;
  bit  hold_req  = 1'b0;
  int  hold_len  = 80;
  int  cur_sp    = 0;
  int  cur_thr   = 0;

  pid_antiwindup_separation uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .measurement(measurement),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive(drive), .integral_active(integral_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly near the setpoint so the integrator sees both sides of the threshold
  function automatic logic signed [DATA_W-1:0] pick_meas();
    int span, v;
    span = (cur_thr > 0 && cur_thr < 65536) ? cur_thr + cur_thr / 4 + 2 : 3000;
    if ($urandom_range(99) < 25) v = int'($signed(16'($urandom)));
    else v = cur_sp + rnd(-span, span);
    return DATA_W'(sat16(v));
  endfunction

  task automatic set_reg(input reg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    if (idx < REG_SEP_THR) cfg_data <= CDATA_W'(val[DATA_W-1:0]);
    else cfg_data <= val[CDATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input int sp, input int kp, input int ki, input int kd,
                              input int hi, input int lo, input int thr, input int lim);
    set_reg(REG_SETPOINT, sp);
    set_reg(REG_GAIN_P, kp);
    set_reg(REG_GAIN_I, ki);
    set_reg(REG_GAIN_D, kd);
    set_reg(REG_UPPER_LIM, hi);
    set_reg(REG_LOWER_LIM, lo);
    set_reg(REG_SEP_THR, thr);
    set_reg(REG_INTEG_LIM, lim);
    cfg_valid <= 1'b0;
    cur_sp  = sp;
    cur_thr = thr;
  endtask

  task automatic send(input logic signed [DATA_W-1:0] m);
    in_valid    <= 1'b1;
    measurement <= m;
    do @(posedge clk); while (!in_ready);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // stop offering and wait until every owed word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_settings(input int ph);
    int sp, kp, ki, kd, hi, lo, thr, lim, tmp;
    sp = (ph == 1) ? 32767 : (ph == 2) ? -32768 : rnd(-32768, 32767);
    if (ph == 3) begin
      kp = -32768; ki = 32767; kd = -32768;
    end else begin
      kp = rnd(-700, 700); ki = rnd(-300, 300); kd = rnd(-500, 500);
    end
    hi = sat16(sp + rnd(0, 3000));
    lo = sat16(sp - rnd(0, 3000));
    if (ph == 4 || ph == 6) begin
      tmp = hi; hi = lo; lo = tmp;
    end
    case (ph % 4)
      0: thr = 65536;
      1: thr = rnd(1, 4000);
      2: thr = rnd(1, 400);
      default: thr = (ph == 7) ? 0 : rnd(1000, 65535);
    endcase
    case (ph % 3)
      0: lim = rnd(0, 200000);
      1: lim = 8388607;
      default: lim = rnd(0, 2000);
    endcase
    if (ph == 5) lim = 0;
    program_regs(sp, kp, ki, kd, hi, lo, thr, lim);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_measurement(measurement);
      if (out_valid && out_ready) sb.check_result(drive, integral_active);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: zero threshold keeps the integral separated
    send(16'sd0);
    send(16'sd32767);
    send(-16'sd32768);
    settle();

    // widest positive error, saturation, limits on both sides, no separation
    program_regs(32767, 256, 256, -256, 100, -100, 65536, 8388607);
    send(-16'sd32768);
    send(16'sd32767);
    send(16'sd0);
    send(16'sd200);
    send(-16'sd200);
    send(16'sd1);
    send(-16'sd1);
    send(16'sd32767);
    settle();

    // widest negative error, swapped limits, zero integral clamp, floor rounding
    program_regs(-32768, 1, -32768, 32767, -100, 100, 1000, 0);
    send(16'sd32767);
    send(-16'sd32768);
    send(-16'sd32767);
    send(-16'sd32500);
    send(-16'sd31000);
    send(16'sd0);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings(ph);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      // fill the pipeline against a stopped receiver
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send(pick_meas());
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
